### rtl/core/fmps_pkg.sv
package fmps_pkg;

	localparam int LEN_W = 6;
	localparam int CNT_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int PAT_BYTES = 32;
	localparam int PAT_IDX_W = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LEN = 3'd0,
		REG_NOCASE      = 3'd1,
		REG_PAT_0_7     = 3'd2,
		REG_PAT_8_15    = 3'd3,
		REG_PAT_16_23   = 3'd4,
		REG_PAT_24_31   = 3'd5
	} cfg_reg_t;

	// Settings the compare stage needs besides the aligned pattern bytes.
	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic             len_ok;
		logic             nocase;
	} match_cfg_t;

	function automatic logic [7:0] fold(input logic [7:0] c, input logic nocase);
		if (nocase && c >= 8'h41 && c <= 8'h5A) begin
			return c + 8'h20;
		end
		return c;
	endfunction

endpackage

### rtl/core/fmps_ifs.sv
interface fmps_byte_if;
	import fmps_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       last_byte;
	modport source (output valid, data_byte, first_byte, last_byte, input ready);
	modport sink (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface fmps_res_if;
	import fmps_pkg::*;
	logic             valid;
	logic             ready;
	logic             found;
	logic [CNT_W-1:0] match_offset;
	modport source (output valid, found, match_offset, input ready);
	modport sink (input valid, found, match_offset, output ready);
endinterface

interface fmps_cfg_if;
	import fmps_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/fmps_cfg.sv
module fmps_cfg import fmps_pkg::*; #(
	parameter int MAX_PATTERN = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	fmps_cfg_if.sink         cfg,
	output match_cfg_t       mcfg,
	output logic [7:0]       pat_al_q [MAX_PATTERN],
	output logic             pat_en_q [MAX_PATTERN]
);

	logic [LEN_W-1:0]          len_q;
	logic                      nocase_q;
	logic [PAT_BYTES*8-1:0]    pat_q;
	logic                      len_ok_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			nocase_q <= 1'b0;
			pat_q    <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_PATTERN_LEN: len_q <= cfg.data[LEN_W-1:0];
				REG_NOCASE:      nocase_q <= cfg.data[0];
				REG_PAT_0_7:     pat_q[0*CFG_DATA_W +: CFG_DATA_W] <= cfg.data;
				REG_PAT_8_15:    pat_q[1*CFG_DATA_W +: CFG_DATA_W] <= cfg.data;
				REG_PAT_16_23:   pat_q[2*CFG_DATA_W +: CFG_DATA_W] <= cfg.data;
				REG_PAT_24_31:   pat_q[3*CFG_DATA_W +: CFG_DATA_W] <= cfg.data;
				default: ;
			endcase
		end
	end

	// The pattern is stored reversed against the window, so that window slot j
	// always meets aligned byte j. The aligned copy is rebuilt in a register after each
	// write, before any item that follows the write reaches the compare.
	logic [7:0] al_d [MAX_PATTERN];
	logic       en_d [MAX_PATTERN];

	always_comb begin
		logic [LEN_W-1:0] idx;
		for (int j = 0; j < MAX_PATTERN; j++) begin
			idx = len_q - LEN_W'(1) - LEN_W'(j);
			en_d[j] = (LEN_W'(j) < len_q);
			if (en_d[j] && idx < LEN_W'(PAT_BYTES)) begin
				al_d[j] = fold(pat_q[idx[PAT_IDX_W-1:0]*8 +: 8], nocase_q);
			end else begin
				al_d[j] = fold(8'h00, nocase_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_ok_q <= 1'b0;
			for (int j = 0; j < MAX_PATTERN; j++) begin
				pat_en_q[j] <= 1'b0;
			end
		end else begin
			len_ok_q <= (len_q != '0) && (7'(len_q) <= 7'(MAX_PATTERN));
			for (int j = 0; j < MAX_PATTERN; j++) begin
				pat_en_q[j] <= en_d[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < MAX_PATTERN; j++) begin
			pat_al_q[j] <= al_d[j];
		end
	end

	assign mcfg.len    = len_q;
	assign mcfg.len_ok = len_ok_q;
	assign mcfg.nocase = nocase_q;

endmodule

### rtl/core/fmps_core.sv
module fmps_core import fmps_pkg::*; #(
	parameter int MAX_PATTERN = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	fmps_byte_if.sink   stream,
	fmps_res_if.source  result,
	input  match_cfg_t  mcfg,
	input  logic [7:0]  pat_al_q [MAX_PATTERN],
	input  logic        pat_en_q [MAX_PATTERN]
);

	logic             valid_s1;
	logic [7:0]       data_s1;
	logic             first_s1;
	logic             last_s1;

	logic [7:0]       win_q [MAX_PATTERN];
	logic [CNT_W-1:0] count_q;
	logic             reported_q;

	logic             out_valid_q;
	logic             found_q;
	logic [CNT_W-1:0] offset_q;

	logic             advance;
	logic [7:0]       win_d [MAX_PATTERN];
	logic [CNT_W-1:0] count_d;
	logic             rep_cur;
	logic             hit;
	logic             emit;

	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			data_s1  <= stream.data_byte;
			first_s1 <= stream.first_byte;
			last_s1  <= stream.last_byte;
		end
	end

	// Slot 0 holds the newest byte.
	always_comb begin
		win_d[0] = data_s1;
		for (int j = 1; j < MAX_PATTERN; j++) begin
			win_d[j] = win_q[j-1];
		end
	end

	always_comb begin
		if (first_s1) begin
			count_d = CNT_W'(1);
		end else if (count_q == '1) begin
			count_d = count_q;
		end else begin
			count_d = count_q + CNT_W'(1);
		end
	end

	always_comb begin
		hit = mcfg.len_ok && (count_d >= CNT_W'(mcfg.len));
		for (int j = 0; j < MAX_PATTERN; j++) begin
			if (pat_en_q[j] && fold(win_d[j], mcfg.nocase) != pat_al_q[j]) begin
				hit = 1'b0;
			end
		end
	end

	assign rep_cur = reported_q && !first_s1;
	assign emit    = !rep_cur && (hit || last_s1);

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int j = 0; j < MAX_PATTERN; j++) begin
				win_q[j] <= win_d[j];
			end
		end
		if (advance && emit) begin
			found_q  <= hit;
			offset_q <= hit ? count_d - CNT_W'(mcfg.len) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			reported_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				count_q    <= count_d;
				reported_q <= rep_cur || hit || last_s1;
				if (emit) begin
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	assign result.valid        = out_valid_q;
	assign result.found        = found_q;
	assign result.match_offset = offset_q;

endmodule

### rtl/core/first_match_pattern_search.sv
// A byte is registered on entry and its result, if any, is registered as the
// byte leaves that input register.
// Throughput: one byte per cycle; the window compare of all pattern slots is
// combinational. Input stalls only while a result waits to be taken.
// Reset (arst_n low) clears configuration, byte count and result state at once.
module first_match_pattern_search import fmps_pkg::*; #(
	parameter int MAX_PATTERN = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	fmps_cfg_if.sink    cfg,
	fmps_byte_if.sink   stream,
	fmps_res_if.source  result
);

	match_cfg_t mcfg;
	logic [7:0] pat_al_q [MAX_PATTERN];
	logic       pat_en_q [MAX_PATTERN];

	fmps_cfg #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.mcfg     (mcfg),
		.pat_al_q (pat_al_q),
		.pat_en_q (pat_en_q)
	);

	fmps_core #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.stream   (stream),
		.result   (result),
		.mcfg     (mcfg),
		.pat_al_q (pat_al_q),
		.pat_en_q (pat_en_q)
	);

	// A miss result never carries an offset.
	a_miss_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.found |-> result.match_offset == '0)
		else $error("miss result with nonzero offset");

	// The input only stalls behind a result that is held back.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!stream.ready |-> result.valid && !result.ready)
		else $error("input stalled without output back-pressure");

	// A disabled pattern can never report a hit.
	a_no_hit_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) && !$past(mcfg.len_ok) |-> !result.found)
		else $error("hit reported with pattern disabled");

endmodule
